### rtl/core/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros shared by the RTL
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Antecedent in one cycle implies the consequent in the next cycle.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/core/dqdel_pkg.sv
// ---------------------------------------------------------------------------
// dqdel_pkg
// Types, sizes and helpers for the linked deque with delete by value.
// ---------------------------------------------------------------------------
package dqdel_pkg;

  localparam int CAPACITY  = 16;
  localparam int DATA_BITS = 32;
  localparam int IDX_W     = $clog2(CAPACITY);
  localparam int CNT_W     = $clog2(CAPACITY + 1);

  // Port field widths
  localparam int MODE_W   = 3;
  localparam int WORD_W   = 32;
  localparam int STAT_W   = 2;
  localparam int COUNT_W  = 5;
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 40;

  typedef enum logic [MODE_W-1:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_POP_FRONT  = 3'd1,
    OP_PUSH_BACK  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_DELETE     = 3'd4
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_FOUND = 2'd3
  } stat_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_UNLINK,
    S_FINISH
  } state_t;

  // Lowest-numbered set bit of the free mask.
  function automatic logic [IDX_W-1:0] lowest_free(input logic [CAPACITY-1:0] mask);
    logic [IDX_W-1:0] idx;
    idx = '0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (mask[i]) begin
        idx = IDX_W'(i);
      end
    end
    return idx;
  endfunction

endpackage

### rtl/core/deque_with_delete_by_value_top.sv
// ---------------------------------------------------------------------------
// deque_with_delete_by_value_top
// Bounded deque of data words kept as a doubly linked list over slots.
// ---------------------------------------------------------------------------
// Usage:
//   Slave channel s_*: one request per beat. s_tuser carries the operation
//   (push front, pop front, push back, pop back, delete first match),
//   s_tdata the word to push or to search for.
//   Master channel m_*: exactly one result beat per request, in order:
//   popped word, status and the entry count after the request.
//   A push, an unknown operation or a pop from an empty deque runs execute
//   and finish; other pops add an unlink step; a delete walks the list from
//   the front in scan steps, unlinking on a hit. The delete walk reads one
//   slot and runs one compare per cycle, which makes it the longest request.
//   A new request is taken the cycle after the previous one has moved into
//   the result register, so requests never overlap in the working stages.
//   Reset empties the queue (all slots free, count zero), holds s_tready low
//   and clears the result valid; no clearing pass over the slot memory.
//   When the receiver stalls, the finished result holds in the output
//   register, one further request may be accepted and worked up to its
//   final step, and the block then waits until the held beat is taken.
// ---------------------------------------------------------------------------
module deque_with_delete_by_value_top (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [dqdel_pkg::IN_TDATA_W-1:0]    s_tdata,   // [31:0] value
  input  logic [dqdel_pkg::MODE_W-1:0]        s_tuser,   // [2:0] mode
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // [31:0] popped_value, [33:32] status, [38:34] entry_count, [39] zero
  output logic [dqdel_pkg::OUT_TDATA_W-1:0]   m_tdata
);
  import dqdel_pkg::*;

  // Slot storage, no reset: only values read from slots holding entries are ever used
  logic [DATA_BITS-1:0] entry_store [CAPACITY];
  logic [IDX_W-1:0]     next_link   [CAPACITY];
  logic [IDX_W-1:0]     prev_link   [CAPACITY];

  // Control state
  state_t               state, state_next;
  logic [IDX_W-1:0]     front_index, back_index;
  logic [CAPACITY-1:0]  free_slots;
  logic [CNT_W-1:0]     count_held;

  // Per-request working registers
  op_t                  op;
  logic [DATA_BITS-1:0] word;
  logic [IDX_W-1:0]     cur;
  logic [CNT_W-1:0]     scan_k;
  logic [DATA_BITS-1:0] popped;
  stat_t                status;

  logic                 accept, out_load;
  logic                 full, empty, is_push, is_pop, push_ok, at_front;
  logic [IDX_W-1:0]     free_slot, pop_slot, rd_addr, nxt_s, prv_s;
  logic [DATA_BITS-1:0] rd_data;
  logic                 hit, scan_end;

  assign accept    = s_tvalid && s_tready;
  assign s_tready  = (state == S_IDLE) && !rst;
  assign full      = (count_held == CNT_W'(CAPACITY));
  assign empty     = (count_held == '0);
  assign is_push   = (op == OP_PUSH_FRONT) || (op == OP_PUSH_BACK);
  assign is_pop    = (op == OP_POP_FRONT) || (op == OP_POP_BACK);
  assign at_front  = (op == OP_PUSH_FRONT);
  assign push_ok   = (state == S_EXEC) && is_push && !full;
  assign free_slot = lowest_free(free_slots);
  assign pop_slot  = (op == OP_POP_FRONT) ? front_index : back_index;

  // Single read port into the slot store, shared by pop and the walk
  assign rd_addr   = (state == S_EXEC) ? pop_slot : cur;
  assign rd_data   = entry_store[rd_addr];
  assign hit       = (rd_data == word);
  assign scan_end  = (scan_k == count_held);
  assign nxt_s     = next_link[cur];
  assign prv_s     = prev_link[cur];
  assign out_load  = (state == S_FINISH) && (!m_tvalid || m_tready);

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (is_pop) begin
          state_next = empty ? S_FINISH : S_UNLINK;
        end else if (op == OP_DELETE) begin
          state_next = S_SCAN;
        end else begin
          state_next = S_FINISH;
        end
      end
      S_SCAN: begin
        if (scan_end) begin
          state_next = S_FINISH;
        end else if (hit) begin
          state_next = S_UNLINK;
        end
      end
      S_UNLINK: state_next = S_FINISH;
      S_FINISH: begin
        if (out_load) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Working registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (accept) begin
          op   <= op_t'(s_tuser);
          word <= DATA_BITS'(s_tdata);
        end
      end
      S_EXEC: begin
        popped <= '0;
        status <= ST_OK;
        if (is_push) begin
          if (full) begin
            status <= ST_FULL;
          end
        end else if (is_pop) begin
          if (empty) begin
            status <= ST_EMPTY;
          end else begin
            popped <= rd_data;
            cur    <= pop_slot;
          end
        end else if (op == OP_DELETE) begin
          cur    <= front_index;
          scan_k <= '0;
        end
      end
      S_SCAN: begin
        if (scan_end) begin
          status <= ST_NOT_FOUND;
        end else if (!hit) begin
          cur    <= nxt_s;
          scan_k <= scan_k + CNT_W'(1);
        end
      end
      default: ;
    endcase
  end

  // Slot store and links
  always_ff @(posedge clk) begin
    if (push_ok) begin
      entry_store[free_slot] <= word;
      if (!empty) begin
        if (at_front) begin
          next_link[free_slot]   <= front_index;
          prev_link[front_index] <= free_slot;
        end else begin
          prev_link[free_slot]  <= back_index;
          next_link[back_index] <= free_slot;
        end
      end
    end else if (state == S_UNLINK && count_held != CNT_W'(1) &&
                 cur != front_index && cur != back_index) begin
      // splice a middle entry out
      next_link[prv_s] <= nxt_s;
      prev_link[nxt_s] <= prv_s;
    end
  end

  // Ends, free mask and count
  always_ff @(posedge clk) begin
    if (rst) begin
      front_index <= '0;
      back_index  <= '0;
      free_slots  <= '1;
      count_held  <= '0;
    end else if (push_ok) begin
      free_slots[free_slot] <= 1'b0;
      count_held            <= count_held + CNT_W'(1);
      if (empty) begin
        front_index <= free_slot;
        back_index  <= free_slot;
      end else if (at_front) begin
        front_index <= free_slot;
      end else begin
        back_index <= free_slot;
      end
    end else if (state == S_UNLINK) begin
      free_slots[cur] <= 1'b1;
      count_held      <= count_held - CNT_W'(1);
      if (count_held == CNT_W'(1)) begin
        front_index <= '0;
        back_index  <= '0;
      end else if (cur == front_index) begin
        front_index <= nxt_s;
      end else if (cur == back_index) begin
        back_index <= prv_s;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {1'b0, COUNT_W'(count_held), STAT_W'(status), WORD_W'(popped)};
    end
  end

`include "assert_macros.svh"

  `ASSERT_ALWAYS(a_count_bound, clk, rst, count_held <= CNT_W'(CAPACITY), "count over capacity")
  `ASSERT_ALWAYS(a_free_match, clk, rst, $countones(~free_slots) == count_held, "mask vs count")
  `ASSERT_ALWAYS(a_scan_bound, clk, rst, state != S_SCAN || scan_k <= count_held, "walk overran")
  `ASSERT_NEXT(a_accept_exec, clk, rst, accept, state == S_EXEC, "accepted request not executed")

endmodule
